// File: rtl/core/tif_pkg.sv
`default_nettype none
package tif_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // traces with either delta component beyond 16.0 count as long
   localparam logic signed [31:0] LONG_TRACE = 32'sh0010_0000;
   localparam logic [15:0] FRAC_TOP = 16'h8000;
   localparam int COORD_SHIFT = 8;
   localparam logic [5:0] MAX_NORM = 6'd32;

   localparam logic [1:0] CSR_TRACE_X  = 2'd0;
   localparam logic [1:0] CSR_TRACE_Y  = 2'd1;
   localparam logic [1:0] CSR_TRACE_DX = 2'd2;
   localparam logic [1:0] CSR_TRACE_DY = 2'd3;

   localparam logic [1:0] OUT_MISS   = 2'd0;
   localparam logic [1:0] OUT_BEHIND = 2'd1;
   localparam logic [1:0] OUT_HIT    = 2'd2;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } trace_type;

   typedef struct packed {
      logic               crossed;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] qx;
      logic signed [31:0] qy;
   } job_type;

endpackage
`default_nettype wire

// File: rtl/core/trace_intercept_fraction.sv
// Path from accept to result word: the classify front (capture, then difference,
// two multiplies and a side compare for each endpoint, then push), then the back
// (queue, 4 multiply steps, a sign check, normalize and shift-subtract steps).
// The front takes a new request only while idle and waits in its push state while
// the queue is full; the back divides only a nonzero, like-signed num and den.
// The receiver cannot stall: each result word shows for one cycle on rsp_valid.
// Synchronous active-high reset clears the trace registers, queue and sequencers.
`default_nettype none
module trace_intercept_fraction (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_mode,
   input  wire signed [15:0]  req_line_x1,
   input  wire signed [15:0]  req_line_y1,
   input  wire signed [15:0]  req_line_x2,
   input  wire signed [15:0]  req_line_y2,
   input  wire signed [15:0]  req_line_dx,
   input  wire signed [15:0]  req_line_dy,
   input  wire signed [31:0]  req_object_x,
   input  wire signed [31:0]  req_object_y,
   input  wire [30:0]         req_object_radius,
   output logic               rsp_valid,
   output logic [1:0]         rsp_outcome,
   output logic signed [31:0] rsp_fraction,
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [31:0]         csr_wdata
);

   tif_pkg::trace_type trace_ff;
   tif_pkg::job_type push_job, head;
   logic push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tif_pkg::CSR_TRACE_X:  trace_ff.x  <= csr_wdata;
            tif_pkg::CSR_TRACE_Y:  trace_ff.y  <= csr_wdata;
            tif_pkg::CSR_TRACE_DX: trace_ff.dx <= csr_wdata;
            tif_pkg::CSR_TRACE_DY: trace_ff.dy <= csr_wdata;
            default: ;
         endcase
      end
   end

   tif_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode),
      .req_line_x1(req_line_x1), .req_line_y1(req_line_y1),
      .req_line_x2(req_line_x2), .req_line_y2(req_line_y2),
      .req_line_dx(req_line_dx), .req_line_dy(req_line_dy),
      .req_object_x(req_object_x), .req_object_y(req_object_y),
      .req_object_radius(req_object_radius),
      .trace(trace_ff), .full(full), .push(push), .push_job(push_job)
   );

   tif_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job), .full(full),
      .pop(pop), .head(head), .empty(empty)
   );

   tif_back u_back (
      .clock(clock), .reset(reset), .trace(trace_ff), .empty(empty), .head(head),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_outcome(rsp_outcome),
      .rsp_fraction(rsp_fraction)
   );

endmodule
`default_nettype wire

// File: rtl/core/tif_front.sv
`default_nettype none
module tif_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire                 req_mode,
   input  wire signed [15:0]   req_line_x1,
   input  wire signed [15:0]   req_line_y1,
   input  wire signed [15:0]   req_line_x2,
   input  wire signed [15:0]   req_line_y2,
   input  wire signed [15:0]   req_line_dx,
   input  wire signed [15:0]   req_line_dy,
   input  wire signed [31:0]   req_object_x,
   input  wire signed [31:0]   req_object_y,
   input  wire [30:0]          req_object_radius,
   input  tif_pkg::trace_type  trace,
   input  wire                 full,
   output logic                push,
   output tif_pkg::job_type    push_job
);

   typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL1, F_MUL2, F_CMP, F_PUSH} fstate_type;

   localparam logic signed [31:0] LONG_TRACE_S = tif_pkg::LONG_TRACE;

   fstate_type state_ff;
   logic sel_ff, use_trace_ff, side1_ff, cross_ff;
   logic signed [31:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, rx_ff, ry_ff;
   logic signed [31:0] ex_ff, ey_ff, mx_ff, my_ff, dxr_ff, dyr_ff, prod1_ff, prod2_ff;
   logic signed [31:0] px_ff, py_ff, qx_ff, qy_ff;

   // entry decode
   logic signed [31:0] lx1_in, ly1_in, lx2_in, ly2_in, ldx_in, ldy_in, rad_in;
   logic signed [31:0] ox1_in, ox2_in, oy1_in, oy2_in;
   logic is_long_in;
   logic signed [31:0] cur_x, cur_y, mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic side;

   always_comb begin
      lx1_in = {req_line_x1, 16'h0000};
      ly1_in = {req_line_y1, 16'h0000};
      lx2_in = {req_line_x2, 16'h0000};
      ly2_in = {req_line_y2, 16'h0000};
      ldx_in = 32'(req_line_dx);
      ldy_in = 32'(req_line_dy);
      rad_in = {1'b0, req_object_radius};
      ox1_in = req_object_x - rad_in;
      ox2_in = req_object_x + rad_in;
      if ((trace.dx ^ trace.dy) > 0) begin
         oy1_in = req_object_y + rad_in;
         oy2_in = req_object_y - rad_in;
      end else begin
         oy1_in = req_object_y - rad_in;
         oy2_in = req_object_y + rad_in;
      end
      is_long_in = (trace.dx > LONG_TRACE_S) || (trace.dy > LONG_TRACE_S) ||
                   (trace.dx < -LONG_TRACE_S) || (trace.dy < -LONG_TRACE_S);
   end

   always_comb begin
      cur_x = sel_ff ? p2x_ff : p1x_ff;
      cur_y = sel_ff ? p2y_ff : p1y_ff;
      if (state_ff == F_MUL1) begin
         mul_a = dyr_ff >>> tif_pkg::COORD_SHIFT;
         mul_b = mx_ff;
      end else begin
         mul_a = my_ff;
         mul_b = dxr_ff >>> tif_pkg::COORD_SHIFT;
      end
      mul_p = mul_a * mul_b;
      priority if (ex_ff == 0) begin
         side = (cur_x <= rx_ff) ? (ey_ff > 0) : (ey_ff < 0);
      end else if (ey_ff == 0) begin
         side = (cur_y <= ry_ff) ? (ex_ff < 0) : (ex_ff > 0);
      end else if (use_trace_ff && ((trace.dy ^ trace.dx ^ dxr_ff ^ dyr_ff) < 0)) begin
         side = (trace.dy ^ dxr_ff) < 0;
      end else begin
         side = prod1_ff >= prod2_ff;
      end
   end

   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH) && !full;
   assign push_job = '{crossed: cross_ff, px: px_ff, py: py_ff, qx: qx_ff, qy: qy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  state_ff <= F_DIFF;
                  sel_ff   <= 1'b0;
                  if (req_mode) begin
                     use_trace_ff <= 1'b1;
                     p1x_ff <= ox1_in;
                     p1y_ff <= oy1_in;
                     p2x_ff <= ox2_in;
                     p2y_ff <= oy2_in;
                     px_ff  <= ox1_in;
                     py_ff  <= oy1_in;
                     qx_ff  <= ox2_in - ox1_in;
                     qy_ff  <= oy2_in - oy1_in;
                  end else begin
                     use_trace_ff <= is_long_in;
                     px_ff <= lx1_in;
                     py_ff <= ly1_in;
                     qx_ff <= {req_line_dx, 16'h0000};
                     qy_ff <= {req_line_dy, 16'h0000};
                     if (is_long_in) begin
                        p1x_ff <= lx1_in;
                        p1y_ff <= ly1_in;
                        p2x_ff <= lx2_in;
                        p2y_ff <= ly2_in;
                     end else begin
                        p1x_ff <= trace.x;
                        p1y_ff <= trace.y;
                        p2x_ff <= trace.x + trace.dx;
                        p2y_ff <= trace.y + trace.dy;
                     end
                  end
                  if (req_mode || is_long_in) begin
                     rx_ff <= trace.x;
                     ry_ff <= trace.y;
                     ex_ff <= trace.dx;
                     ey_ff <= trace.dy;
                     mx_ff <= trace.dx >>> 16;
                     my_ff <= trace.dy >>> 16;
                  end else begin
                     rx_ff <= lx1_in;
                     ry_ff <= ly1_in;
                     ex_ff <= ldx_in;
                     ey_ff <= ldy_in;
                     mx_ff <= ldx_in;
                     my_ff <= ldy_in;
                  end
               end
            end
            F_DIFF: begin
               dxr_ff   <= cur_x - rx_ff;
               dyr_ff   <= cur_y - ry_ff;
               state_ff <= F_MUL1;
            end
            F_MUL1: begin
               prod1_ff <= mul_p[31:0];
               state_ff <= F_MUL2;
            end
            F_MUL2: begin
               prod2_ff <= mul_p[31:0];
               state_ff <= F_CMP;
            end
            F_CMP: begin
               if (!sel_ff) begin
                  side1_ff <= side;
                  sel_ff   <= 1'b1;
                  state_ff <= F_DIFF;
               end else begin
                  cross_ff <= side1_ff ^ side;
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/tif_queue.sv
`default_nettype none
module tif_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  tif_pkg::job_type  push_job,
   output logic              full,
   input  wire               pop,
   output tif_pkg::job_type  head,
   output logic              empty
);

   localparam int CNT_W = tif_pkg::QPTR_W + 1;

   tif_pkg::job_type slot_ff [tif_pkg::QUEUE_DEPTH];
   logic [tif_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == CNT_W'(tif_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= push_job;
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/tif_back.sv
`default_nettype none
module tif_back (
   input  wire                 clock,
   input  wire                 reset,
   input  tif_pkg::trace_type  trace,
   input  wire                 empty,
   input  tif_pkg::job_type    head,
   output logic                pop,
   output logic                rsp_valid,
   output logic [1:0]          rsp_outcome,
   output logic signed [31:0]  rsp_fraction
);

   typedef enum logic [2:0] {B_IDLE, B_MUL, B_NUM, B_NORM, B_INT, B_FRAC, B_OUT} bstate_type;

   bstate_type state_ff;
   tif_pkg::job_type job_ff;
   logic [1:0] step_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff, da_ff, db_ff;
   logic [15:0] ibit_ff, ch_ff, cl_ff;
   logic [5:0] n_ff;
   logic valid_ff;
   logic [1:0] outcome_ff;
   logic signed [31:0] fraction_ff;

   logic signed [31:0] mul_a, mul_b, num, den, diff;
   logic signed [63:0] mul_p;
   logic ge;

   always_comb begin
      unique case (step_ff)
         2'd0: begin
            mul_a = job_ff.qy >>> 16;
            mul_b = (job_ff.px - trace.x) >>> tif_pkg::COORD_SHIFT;
         end
         2'd1: begin
            mul_a = job_ff.qx >>> 16;
            mul_b = (trace.y - job_ff.py) >>> tif_pkg::COORD_SHIFT;
         end
         2'd2: begin
            mul_a = trace.dx;
            mul_b = job_ff.qy >>> tif_pkg::COORD_SHIFT;
         end
         default: begin
            mul_a = trace.dy;
            mul_b = job_ff.qx >>> tif_pkg::COORD_SHIFT;
         end
      endcase
      mul_p = mul_a * mul_b;
      num   = a_ff + b_ff;
      den   = c_ff - d_ff;
      ge    = da_ff >= db_ff;
      diff  = da_ff - db_ff;
   end

   assign pop          = (state_ff == B_IDLE) && !empty;
   assign rsp_valid    = valid_ff;
   assign rsp_outcome  = outcome_ff;
   assign rsp_fraction = fraction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         step_ff  <= 2'd0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  job_ff  <= head;
                  step_ff <= 2'd0;
                  if (head.crossed) begin
                     state_ff <= B_MUL;
                  end else begin
                     valid_ff    <= 1'b1;
                     outcome_ff  <= tif_pkg::OUT_MISS;
                     fraction_ff <= '0;
                  end
               end
            end
            B_MUL: begin
               unique case (step_ff)
                  2'd0: a_ff <= mul_p[31:0];
                  2'd1: b_ff <= mul_p[31:0];
                  2'd2: c_ff <= mul_p[47:16];
                  default: d_ff <= mul_p[47:16];
               endcase
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) state_ff <= B_NUM;
            end
            B_NUM: begin
               priority if (num == 0 || den == 0) begin
                  valid_ff    <= 1'b1;
                  outcome_ff  <= tif_pkg::OUT_HIT;
                  fraction_ff <= '0;
                  state_ff    <= B_IDLE;
               end else if ((num ^ den) < 0) begin
                  valid_ff    <= 1'b1;
                  outcome_ff  <= tif_pkg::OUT_BEHIND;
                  fraction_ff <= '0;
                  state_ff    <= B_IDLE;
               end else begin
                  da_ff    <= (num < 0) ? -num : num;
                  db_ff    <= (num < 0) ? -den : den;
                  ibit_ff  <= 16'd1;
                  n_ff     <= '0;
                  ch_ff    <= '0;
                  cl_ff    <= '0;
                  state_ff <= B_NORM;
               end
            end
            B_NORM: begin
               // line the divisor up under the dividend
               if (db_ff < da_ff && n_ff < tif_pkg::MAX_NORM) begin
                  db_ff   <= db_ff <<< 1;
                  ibit_ff <= ibit_ff << 1;
                  n_ff    <= n_ff + 6'd1;
               end else begin
                  state_ff <= B_INT;
               end
            end
            B_INT: begin
               if (ibit_ff == '0) begin
                  ibit_ff  <= tif_pkg::FRAC_TOP;
                  state_ff <= B_FRAC;
               end else begin
                  if (ge) begin
                     da_ff <= diff <<< 1;
                     ch_ff <= ch_ff | ibit_ff;
                  end else begin
                     da_ff <= da_ff <<< 1;
                  end
                  ibit_ff <= ibit_ff >> 1;
               end
            end
            B_FRAC: begin
               if (ge) begin
                  da_ff <= diff <<< 1;
                  cl_ff <= cl_ff | ibit_ff;
               end else begin
                  da_ff <= da_ff <<< 1;
               end
               ibit_ff <= ibit_ff >> 1;
               if (ibit_ff == 16'd1) state_ff <= B_OUT;
            end
            B_OUT: begin
               valid_ff <= 1'b1;
               if (ch_ff[15]) begin
                  outcome_ff  <= tif_pkg::OUT_BEHIND;
                  fraction_ff <= '0;
               end else begin
                  outcome_ff  <= tif_pkg::OUT_HIT;
                  fraction_ff <= {ch_ff, cl_ff};
               end
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: bench/tif_checker.sv
`timescale 1ns / 1ps
module tif_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  wire                req_mode,
   input  wire signed [15:0]  req_line_x1,
   input  wire signed [15:0]  req_line_y1,
   input  wire signed [15:0]  req_line_x2,
   input  wire signed [15:0]  req_line_y2,
   input  wire signed [15:0]  req_line_dx,
   input  wire signed [15:0]  req_line_dy,
   input  wire signed [31:0]  req_object_x,
   input  wire signed [31:0]  req_object_y,
   input  wire [30:0]         req_object_radius,
   input  wire                rsp_valid,
   input  wire [1:0]          rsp_outcome,
   input  wire signed [31:0]  rsp_fraction,
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [31:0]         csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] fraction;
   } hit_word_type;

   tif_pkg::trace_type trc;
   hit_word_type hit_q[$];

   assign pending = hit_q.size();

   function automatic logic [31:0] asr_n(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] fix_mul(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[47:16];
   endfunction

   function automatic logic [31:0] fix_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ibit, ch, cl, bt;
      int n;
      ibit = 1; ch = 0; cl = 0; n = 0;
      if ($signed(a) < 0) begin
         a = -a;
         b = -b;
      end
      while ($signed(b) < $signed(a) && n < 32) begin
         b = b << 1;
         ibit = (ibit << 1) & 32'hFFFF;
         n++;
      end
      while (ibit != 0) begin
         if ($signed(a) >= $signed(b)) begin
            a = a - b;
            ch |= ibit;
         end
         a = a << 1;
         ibit = ibit >> 1;
      end
      bt = 32'h8000;
      while (bt != 0) begin
         if ($signed(a) >= $signed(b)) begin
            a = a - b;
            cl |= bt;
         end
         a = a << 1;
         bt = bt >> 1;
      end
      return (ch << 16) | cl;
   endfunction

   function automatic bit side_of_trace(logic [31:0] x, logic [31:0] y);
      logic [31:0] l, r;
      if (trc.dx == 0)
         return $signed(x) <= trc.x ? trc.dy > 0 : trc.dy < 0;
      if (trc.dy == 0)
         return $signed(y) <= trc.y ? trc.dx < 0 : trc.dx > 0;
      x = x - trc.x;
      y = y - trc.y;
      if ($signed(trc.dy ^ trc.dx ^ x ^ y) < 0)
         return $signed(trc.dy ^ x) < 0;
      l = asr_n(y, tif_pkg::COORD_SHIFT) * asr_n(trc.dx, 16);
      r = asr_n(trc.dy, 16) * asr_n(x, tif_pkg::COORD_SHIFT);
      return $signed(l) >= $signed(r);
   endfunction

   function automatic bit side_of_line(logic [31:0] x, logic [31:0] y, logic [31:0] lx,
                                       logic [31:0] ly, logic [31:0] ldx, logic [31:0] ldy);
      logic [31:0] l, r;
      if (ldx == 0)
         return $signed(x) <= $signed(lx) ? $signed(ldy) > 0 : $signed(ldy) < 0;
      if (ldy == 0)
         return $signed(y) <= $signed(ly) ? $signed(ldx) < 0 : $signed(ldx) > 0;
      l = asr_n(y - ly, tif_pkg::COORD_SHIFT) * ldx;
      r = ldy * asr_n(x - lx, tif_pkg::COORD_SHIFT);
      return $signed(l) >= $signed(r);
   endfunction

   function automatic hit_word_type predict_crossing();
      logic [31:0] px, py, qx, qy, x1, x2, y1, y2, r, num, den, frac;
      bit s1, s2;
      hit_word_type w;
      if (!req_mode) begin
         px = {req_line_x1, 16'h0};
         py = {req_line_y1, 16'h0};
         qx = {req_line_dx, 16'h0};
         qy = {req_line_dy, 16'h0};
         if (trc.dx > tif_pkg::LONG_TRACE || trc.dy > tif_pkg::LONG_TRACE ||
             trc.dx < -tif_pkg::LONG_TRACE || trc.dy < -tif_pkg::LONG_TRACE) begin
            s1 = side_of_trace(px, py);
            s2 = side_of_trace({req_line_x2, 16'h0}, {req_line_y2, 16'h0});
         end else begin
            s1 = side_of_line(trc.x, trc.y, px, py, 32'(req_line_dx), 32'(req_line_dy));
            s2 = side_of_line(trc.x + trc.dx, trc.y + trc.dy, px, py,
                              32'(req_line_dx), 32'(req_line_dy));
         end
      end else begin
         r = {1'b0, req_object_radius};
         x1 = req_object_x - r;
         x2 = req_object_x + r;
         if ($signed(trc.dx ^ trc.dy) > 0) begin
            y1 = req_object_y + r;
            y2 = req_object_y - r;
         end else begin
            y1 = req_object_y - r;
            y2 = req_object_y + r;
         end
         s1 = side_of_trace(x1, y1);
         s2 = side_of_trace(x2, y2);
         px = x1; py = y1; qx = x2 - x1; qy = y2 - y1;
      end
      w = '{tif_pkg::OUT_MISS, 32'h0};
      if (s1 == s2)
         return w;
      num = asr_n(qy, 16) * asr_n(px - trc.x, tif_pkg::COORD_SHIFT)
          + asr_n(qx, 16) * asr_n(trc.y - py, tif_pkg::COORD_SHIFT);
      den = fix_mul(trc.dx, asr_n(qy, tif_pkg::COORD_SHIFT))
          - fix_mul(trc.dy, asr_n(qx, tif_pkg::COORD_SHIFT));
      if (num == 0 || den == 0)
         frac = 0;
      else if ($signed(num ^ den) < 0)
         frac = 32'hFFFF_FFFF;
      else
         frac = fix_div(num, den);
      if ($signed(frac) < 0)
         w.outcome = tif_pkg::OUT_BEHIND;
      else begin
         w.outcome = tif_pkg::OUT_HIT;
         w.fraction = frac;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      hit_word_type exp_w;
      if (reset) begin
         trc <= '0;
         hit_q.delete();
         fail_count <= 0;
      end else begin
         if (start && !busy)
            hit_q.push_back(predict_crossing());
         if (rsp_valid) begin
            if (hit_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected word: outcome %0d fraction %h", rsp_outcome, rsp_fraction);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = hit_q.pop_front();
               if (exp_w.outcome !== rsp_outcome || exp_w.fraction !== rsp_fraction) begin
                  if (fail_count < 10)
                     $display("mismatch: expected outcome %0d fraction %h, got %0d %h",
                              exp_w.outcome, exp_w.fraction, rsp_outcome, rsp_fraction);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we)
            case (csr_index)
               tif_pkg::CSR_TRACE_X:  trc.x <= csr_wdata;
               tif_pkg::CSR_TRACE_Y:  trc.y <= csr_wdata;
               tif_pkg::CSR_TRACE_DX: trc.dx <= csr_wdata;
               tif_pkg::CSR_TRACE_DY: trc.dy <= csr_wdata;
               default: ;
            endcase
      end
   end

endmodule

// File: bench/tb_trace_intercept_fraction.sv
`timescale 1ns / 1ps
module tb_trace_intercept_fraction;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_mode = 0;
   logic signed [15:0] req_line_x1 = 0, req_line_y1 = 0, req_line_x2 = 0, req_line_y2 = 0;
   logic signed [15:0] req_line_dx = 0, req_line_dy = 0;
   logic signed [31:0] req_object_x = 0, req_object_y = 0;
   logic [30:0] req_object_radius = 0;
   logic rsp_valid;
   logic [1:0] rsp_outcome;
   logic signed [31:0] rsp_fraction;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;
   int fail_count, pending;
   int cycle_count = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   trace_intercept_fraction u_top (.*);
   tif_checker u_chk (.*);

   function automatic logic [31:0] rand_fixed(int pick);
      case (pick)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         2: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
         default: return {16'($urandom_range(0, 255) - 128), 16'h0};
      endcase
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic load_trace(logic [31:0] x, logic [31:0] y, logic [31:0] dx, logic [31:0] dy);
      // drain before touching the trace
      while (pending != 0) @(negedge clock);
      repeat (90) @(negedge clock);
      write_csr(tif_pkg::CSR_TRACE_X, x);
      write_csr(tif_pkg::CSR_TRACE_Y, y);
      write_csr(tif_pkg::CSR_TRACE_DX, dx);
      write_csr(tif_pkg::CSR_TRACE_DY, dy);
   endtask

   // drive one word at the falling edge, hold start until the front is idle again
   task automatic send_word(bit mode, logic [15:0] x1, y1, x2, y2, ldx, ldy,
                            logic [31:0] ox, oy, logic [30:0] rad);
      @(negedge clock);
      req_mode <= mode;
      req_line_x1 <= x1; req_line_y1 <= y1; req_line_x2 <= x2; req_line_y2 <= y2;
      req_line_dx <= ldx; req_line_dy <= ldy;
      req_object_x <= ox; req_object_y <= oy; req_object_radius <= rad;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start <= 0;
   endtask

   task automatic send_random(int scale);
      logic [15:0] x1, y1, x2, y2;
      int span;
      span = scale ? 32767 : 200;
      x1 = 16'($urandom_range(0, 2 * span) - span);
      y1 = 16'($urandom_range(0, 2 * span) - span);
      x2 = 16'($urandom_range(0, 2 * span) - span);
      y2 = 16'($urandom_range(0, 2 * span) - span);
      if ($urandom_range(0, 9) == 0)
         send_word(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom, $urandom, 31'($urandom));
      else if ($urandom_range(0, 1))
         send_word(1'b0, x1, y1, x2, y2, x2 - x1, y2 - y1, $urandom, $urandom,
                   31'($urandom));
      else
         send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom),
                   rand_fixed(scale ? 0 : 3), rand_fixed(scale ? 0 : 3),
                   scale ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000)));
   endtask

   initial begin
      int gap;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: reset trace, then a long diagonal trace
      send_word(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                32'd0, 32'd0, 31'd0);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      load_trace(32'h0, 32'h0, 32'h0040_0000, 32'h0040_0000);
      send_word(1'b0, 16'sd10, -16'sd5, 16'sd10, 16'sd50, 16'sd0, 16'sd55,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, -16'sd5, 16'sd10, 16'sd50, 16'sd10, 16'sd55, 16'sd0,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, 16'sd0, 16'sd0, 16'sd64, 16'sd64, 16'sd64, 16'sd64,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, 16'sd100, -16'sd100, -16'sd100, 16'sd100, -16'sd200, 16'sd200,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                32'd0, 32'd0, 31'd0);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'h0020_0000, 32'h0020_0000, 31'h0001_0000);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'hFFF0_0000, 32'hFFF0_0000, 31'h0001_0000);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'h0020_0000, 32'h0000_0000, 31'h0);
      load_trace(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(1'b0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
                32'd0, 32'd0, 31'd0);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'h0, 32'h0, 31'h7FFF_FFFF);
      load_trace(32'h0001_8000, 32'hFFFF_0000, 32'h0008_0000, 32'h0);
      send_word(1'b0, 16'sd3, -16'sd4, 16'sd3, 16'sd4, 16'sd0, 16'sd8,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, -16'sd3, -16'sd4, -16'sd3, 16'sd4, 16'sd0, 16'sd8,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, 16'sd0, 16'sd2, 16'sd9, 16'sd2, 16'sd9, 16'sd0,
                32'd0, 32'd0, 31'd0);
      load_trace(32'h0, 32'h0, 32'h0, 32'hFFF8_0000);
      send_word(1'b0, -16'sd2, -16'sd2, 16'sd2, -16'sd2, 16'sd4, 16'sd0,
                32'd0, 32'd0, 31'd0);
      send_word(1'b0, -16'sd2, -16'sd2, 16'sd2, -16'sd5, 16'sd4, -16'sd3,
                32'd0, 32'd0, 31'd0);
      send_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                32'h0, 32'hFFF0_0000, 31'h0002_0000);
      // random phases, short and long traces
      for (int ph = 0; ph < 13; ph++) begin
         case (ph % 3)
            0: load_trace($urandom, $urandom, $urandom, $urandom);
            1: load_trace(rand_fixed(3), rand_fixed(3), rand_fixed(2), rand_fixed(2));
            default: load_trace(rand_fixed(1), rand_fixed(1), rand_fixed(1), rand_fixed(1));
         endcase
         for (int i = 0; i < 150; i++) begin
            send_random(ph % 3 == 0);
            if ($urandom_range(0, 3) == 0) begin
               gap = $urandom_range(1, 60);
               repeat (gap) @(negedge clock);
            end
         end
      end
      while (pending != 0) @(negedge clock);
      repeat (90) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/tif_pkg.sv
rtl/core/tif_front.sv
rtl/core/tif_queue.sv
rtl/core/tif_back.sv
rtl/core/trace_intercept_fraction.sv
bench/tif_checker.sv
bench/tb_trace_intercept_fraction.sv
